@@ hw/rtl/cst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore table package
// Shared widths, codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int NUM_RESOURCES_DEF = 8;
  localparam int NUM_PIDS_DEF      = 32;
  localparam int WAIT_DEPTH_DEF    = 4;

  localparam int ACT_W  = 2;
  localparam int RES_W  = 3;
  localparam int PID_W  = 5;
  localparam int KIND_W = 3;
  localparam int CNT_W  = 8;
  localparam int HELD_W = 8;

  localparam logic signed [CNT_W-1:0] SEM_ZERO = '0;
  localparam logic signed [CNT_W-1:0] SEM_ONE  = CNT_W'(1);
  localparam logic signed [CNT_W-1:0] SEM_MAX  = CNT_W'(127);
  localparam logic signed [CNT_W-1:0] SEM_MIN  = CNT_W'(-128);
  localparam logic [HELD_W-1:0]       HELD_MAX = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_WAIT    = 2'd0,
    ACT_SIGNAL  = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_IGNORE  = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANTED  = 3'd0,
    KIND_BLOCKED  = 3'd1,
    KIND_REFUSED  = 3'd2,
    KIND_SIGNALED = 3'd3,
    KIND_WOKEN    = 3'd4,
    KIND_RELEASED = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    HELD_INC  = 2'd0,
    HELD_DEC  = 2'd1,
    HELD_ZERO = 2'd2
  } held_fn_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_RD,
    ST_W_EXEC,
    ST_S_RD,
    ST_S_DEC,
    ST_GB_UP,
    ST_GB_POP,
    ST_GB_QRD,
    ST_GB_HUP,
    ST_GB_SREQ,
    ST_GB_SCHK,
    ST_GB_WAKE,
    ST_S_DONE,
    ST_R_SETUP,
    ST_R_DREQ,
    ST_R_DCHK,
    ST_R_DFIN,
    ST_R_HGET,
    ST_R_HLOOP,
    ST_R_NEXT,
    ST_R_DONE
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     clr_step;
    logic     held_rd;
    logic     held_wr;
    logic     held_q;
    held_fn_t held_fn;
    logic     wait_exec;
    logic     gb_up;
    logic     gb_pop;
    logic     scan_init;
    logic     scan_rd;
    logic     scan_step;
    logic     drop_chk;
    logic     drop_fin;
    logic     h_load;
    logic     h_dec;
    logic     res_inc;
    logic     emit;
    kind_t    kind;
  } cst_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic act_release;
    logic gb_wake;
    logic scan_end;
    logic scan_hit;
    logic h_zero;
    logic res_last;
  } cst_stat_t;

endpackage

@@ hw/rtl/cst_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore table channels
// Request and result channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface cst_in_if import cst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [RES_W-1:0] resource;
  logic [PID_W-1:0] pid;

  modport source (output valid, output action, output resource, output pid, input ready);
  modport sink (input valid, input action, input resource, input pid, output ready);
endinterface

interface cst_out_if import cst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PID_W-1:0]  who;
  logic [RES_W-1:0]  which_resource;
  logic              last;

  modport source (output valid, output kind, output who, output which_resource, output last,
                  input ready);
  modport sink (input valid, input kind, input who, input which_resource, input last,
                output ready);
endinterface

@@ hw/rtl/cst_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/cst_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore table datapath
// Counts, queue pointers, the wait queue and held count memories, and the
// result register.
// ----------------------------------------------------------------------------
module cst_dp import cst_pkg::*; #(
  parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
  parameter int NUM_PIDS      = NUM_PIDS_DEF,
  parameter int WAIT_DEPTH    = WAIT_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [ACT_W-1:0] in_action,
  input  logic [RES_W-1:0] in_resource,
  input  logic [PID_W-1:0] in_pid,
  input  cst_cmd_t         cmd,
  output cst_stat_t        stat,
  cst_out_if.source        out_ch
);

  localparam int RW    = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int PW    = $clog2(NUM_PIDS);
  localparam int DW    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int FW    = $clog2(WAIT_DEPTH + 1);
  localparam int SW    = FW + 1;
  localparam int HAW   = RW + PW;
  localparam int QAW   = RW + DW;
  localparam int HDEPTH = 1 << HAW;
  localparam int QDEPTH = 1 << QAW;

  function automatic logic [RW-1:0] fold_res(input logic [RES_W-1:0] v);
    int m;
    m = 0;
    for (int k = 1; k < (1 << RES_W); k++) begin
      if (int'(v) >= k * NUM_RESOURCES) m = k;
    end
    return RW'(int'(v) - m * NUM_RESOURCES);
  endfunction

  function automatic logic [PW-1:0] fold_pid(input logic [PID_W-1:0] v);
    int m;
    m = 0;
    for (int k = 1; k < (1 << PID_W); k++) begin
      if (int'(v) >= k * NUM_PIDS) m = k;
    end
    return PW'(int'(v) - m * NUM_PIDS);
  endfunction

  function automatic logic [DW-1:0] ring(input logic [DW-1:0] base, input logic [FW-1:0] ofs);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(ofs);
    if (s >= SW'(WAIT_DEPTH)) s = s - SW'(WAIT_DEPTH);
    return DW'(s);
  endfunction

  logic [ACT_W-1:0]        act_r;
  logic [RW-1:0]           res_r;
  logic [PW-1:0]           pid_r;
  logic [PW-1:0]           q_r;
  logic [HELD_W-1:0]       h_r;
  logic [FW-1:0]           i_r;
  logic [FW-1:0]           kcnt_r;
  logic [HAW-1:0]          clr_r;
  logic signed [CNT_W-1:0] sem_r    [NUM_RESOURCES];
  logic signed [CNT_W-1:0] sem_nxt  [NUM_RESOURCES];
  logic [DW-1:0]           head_r   [NUM_RESOURCES];
  logic [DW-1:0]           head_nxt [NUM_RESOURCES];
  logic [FW-1:0]           fill_r   [NUM_RESOURCES];
  logic [FW-1:0]           fill_nxt [NUM_RESOURCES];

  logic                    out_valid_r;
  logic [KIND_W-1:0]       out_kind_r;
  logic [PID_W-1:0]        out_who_r;
  logic [RES_W-1:0]        out_res_r;
  logic                    out_last_r;

  logic signed [CNT_W-1:0] sem_cur;
  logic signed [CNT_W-1:0] sem_inc;
  logic signed [CNT_W-1:0] sem_dec;
  logic [DW-1:0]           head_cur;
  logic [FW-1:0]           fill_cur;
  logic                    grant;
  logic                    full;
  logic                    drop_hit;
  logic                    out_free;
  logic                    do_emit;
  kind_t                   emit_kind;
  kind_t                   wait_kind;

  logic [HELD_W-1:0]       held_dout;
  logic [HELD_W-1:0]       held_din;
  logic [PW-1:0]           held_pid;
  logic                    held_we;
  logic [HAW-1:0]          held_waddr;
  logic [PW-1:0]           queue_dout;
  logic [PW-1:0]           queue_din;
  logic                    queue_we;
  logic                    queue_re;
  logic [DW-1:0]           queue_rslot;
  logic [DW-1:0]           queue_wslot;

  assign sem_cur  = sem_r[res_r];
  assign head_cur = head_r[res_r];
  assign fill_cur = fill_r[res_r];
  assign sem_inc  = (sem_cur == SEM_MAX) ? sem_cur : sem_cur + SEM_ONE;
  assign sem_dec  = (sem_cur == SEM_MIN) ? sem_cur : sem_cur - SEM_ONE;
  assign grant    = sem_cur > SEM_ZERO;
  assign full     = fill_cur >= FW'(WAIT_DEPTH);
  assign drop_hit = queue_dout == pid_r;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    if (grant) begin
      wait_kind = KIND_GRANTED;
    end else if (full) begin
      wait_kind = KIND_REFUSED;
    end else begin
      wait_kind = KIND_BLOCKED;
    end
  end

  assign do_emit   = cmd.emit || cmd.wait_exec;
  assign emit_kind = cmd.wait_exec ? wait_kind : cmd.kind;

  // Held count memory.
  assign held_pid   = cmd.held_q ? q_r : pid_r;
  assign held_we    = cmd.clr_step || cmd.held_wr || (cmd.wait_exec && grant);
  assign held_waddr = cmd.clr_step ? clr_r : {res_r, held_pid};

  always_comb begin
    if (cmd.clr_step) begin
      held_din = '0;
    end else if (cmd.wait_exec) begin
      held_din = (held_dout == HELD_MAX) ? held_dout : held_dout + HELD_W'(1);
    end else begin
      case (cmd.held_fn)
        HELD_INC:  held_din = (held_dout == HELD_MAX) ? held_dout : held_dout + HELD_W'(1);
        HELD_DEC:  held_din = (held_dout == '0) ? held_dout : held_dout - HELD_W'(1);
        default:   held_din = '0;
      endcase
    end
  end

  cst_ram #(
    .WIDTH (HELD_W),
    .DEPTH (HDEPTH)
  ) u_held_ram (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_waddr),
    .wdata (held_din),
    .re    (cmd.held_rd),
    .raddr ({res_r, held_pid}),
    .rdata (held_dout)
  );

  // Wait queue memory, one ring of slots per resource.
  assign queue_rslot = ring(head_cur, cmd.gb_up ? '0 : i_r);
  assign queue_wslot = ring(head_cur, cmd.wait_exec ? fill_cur : kcnt_r);
  assign queue_re    = cmd.gb_up || cmd.scan_rd;
  assign queue_we    = (cmd.wait_exec && !grant && !full) || (cmd.drop_chk && !drop_hit);
  assign queue_din   = cmd.wait_exec ? pid_r : queue_dout;

  cst_ram #(
    .WIDTH (PW),
    .DEPTH (QDEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (queue_we),
    .waddr ({res_r, queue_wslot}),
    .wdata (queue_din),
    .re    (queue_re),
    .raddr ({res_r, queue_rslot}),
    .rdata (queue_dout)
  );

  always_comb begin
    sem_nxt  = sem_r;
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (cmd.wait_exec) begin
      if (grant) begin
        sem_nxt[res_r] = sem_cur - SEM_ONE;
      end else if (!full) begin
        sem_nxt[res_r]  = sem_dec;
        fill_nxt[res_r] = fill_cur + FW'(1);
      end
    end
    if (cmd.gb_up || (cmd.drop_chk && drop_hit)) begin
      sem_nxt[res_r] = sem_inc;
    end
    if (cmd.gb_pop) begin
      head_nxt[res_r] = ring(head_cur, FW'(1));
      fill_nxt[res_r] = fill_cur - FW'(1);
    end
    if (cmd.drop_fin) begin
      fill_nxt[res_r] = kcnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_RESOURCES; k++) begin
        sem_r[k]  <= SEM_ONE;
        head_r[k] <= '0;
        fill_r[k] <= '0;
      end
      clr_r <= '0;
    end else begin
      sem_r  <= sem_nxt;
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      if (cmd.clr_step) begin
        clr_r <= clr_r + HAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      res_r <= '0;
      pid_r <= '0;
    end else if (cmd.accept) begin
      act_r <= in_action;
      res_r <= (in_action == ACT_RELEASE) ? '0 : fold_res(in_resource);
      pid_r <= fold_pid(in_pid);
    end else if (cmd.res_inc) begin
      res_r <= res_r + RW'(1);
    end
    if (cmd.gb_pop) begin
      q_r <= queue_dout;
    end
    if (cmd.h_load) begin
      h_r <= held_dout;
    end else if (cmd.h_dec) begin
      h_r <= h_r - HELD_W'(1);
    end
    if (cmd.scan_init) begin
      i_r    <= '0;
      kcnt_r <= '0;
    end else if (cmd.scan_step) begin
      i_r <= i_r + FW'(1);
    end else if (cmd.drop_chk) begin
      i_r <= i_r + FW'(1);
      if (!drop_hit) begin
        kcnt_r <= kcnt_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_kind_r <= emit_kind;
      out_who_r  <= (emit_kind == KIND_WOKEN) ? PID_W'(q_r) : PID_W'(pid_r);
      out_res_r  <= (emit_kind == KIND_RELEASED) ? '0 : RES_W'(res_r);
      out_last_r <= emit_kind != KIND_WOKEN;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_kind_r;
  assign out_ch.who            = out_who_r;
  assign out_ch.which_resource = out_res_r;
  assign out_ch.last           = out_last_r;

  assign stat.clr_last    = &clr_r;
  assign stat.out_free    = out_free;
  assign stat.act_release = act_r == ACT_RELEASE;
  assign stat.gb_wake     = (sem_inc <= SEM_ZERO) && (fill_cur != '0);
  assign stat.scan_end    = i_r == fill_cur;
  assign stat.scan_hit    = queue_dout == q_r;
  assign stat.h_zero      = h_r == '0;
  assign stat.res_last    = res_r == RW'(NUM_RESOURCES - 1);

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cur <= FW'(WAIT_DEPTH))
    else $error("queue fill above depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    do_emit |-> out_free)
    else $error("result issued while result register busy");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gb_pop |-> fill_cur != '0)
    else $error("pop from empty wait queue");

  a_keep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop_chk |-> kcnt_r <= i_r)
    else $error("compaction write ahead of scan");
`endif

endmodule

@@ hw/rtl/cst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore table controller
// Sequences the clearing pass, waits, signals and releases over the datapath.
// ----------------------------------------------------------------------------
module cst_ctrl import cst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [ACT_W-1:0] in_action,
  output logic             in_ready,
  input  cst_stat_t        stat,
  output cst_cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;
  state_t ret_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign ret_st = stat.act_release ? ST_R_HLOOP : ST_S_DONE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_action)
            ACT_WAIT:    state_nxt = ST_W_RD;
            ACT_SIGNAL:  state_nxt = ST_S_RD;
            ACT_RELEASE: state_nxt = ST_R_SETUP;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_W_RD: begin
        cmd.held_rd = 1'b1;
        state_nxt   = ST_W_EXEC;
      end
      ST_W_EXEC: begin
        if (stat.out_free) begin
          cmd.wait_exec = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_S_RD: begin
        cmd.held_rd = 1'b1;
        state_nxt   = ST_S_DEC;
      end
      ST_S_DEC: begin
        cmd.held_wr = 1'b1;
        cmd.held_fn = HELD_DEC;
        state_nxt   = ST_GB_UP;
      end
      ST_GB_UP: begin
        cmd.gb_up = 1'b1;
        state_nxt = stat.gb_wake ? ST_GB_POP : ret_st;
      end
      ST_GB_POP: begin
        cmd.gb_pop = 1'b1;
        state_nxt  = ST_GB_QRD;
      end
      ST_GB_QRD: begin
        cmd.held_rd = 1'b1;
        cmd.held_q  = 1'b1;
        state_nxt   = ST_GB_HUP;
      end
      ST_GB_HUP: begin
        cmd.held_wr   = 1'b1;
        cmd.held_q    = 1'b1;
        cmd.held_fn   = HELD_INC;
        cmd.scan_init = 1'b1;
        state_nxt     = ST_GB_SREQ;
      end
      ST_GB_SREQ: begin
        if (stat.scan_end) begin
          state_nxt = ST_GB_WAKE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = ST_GB_SCHK;
        end
      end
      ST_GB_SCHK: begin
        if (stat.scan_hit) begin
          state_nxt = ret_st;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = ST_GB_SREQ;
        end
      end
      ST_GB_WAKE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_WOKEN;
          state_nxt = ret_st;
        end
      end
      ST_S_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_SIGNALED;
          state_nxt = ST_IDLE;
        end
      end
      ST_R_SETUP: begin
        cmd.scan_init = 1'b1;
        state_nxt     = ST_R_DREQ;
      end
      ST_R_DREQ: begin
        if (stat.scan_end) begin
          state_nxt = ST_R_DFIN;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = ST_R_DCHK;
        end
      end
      ST_R_DCHK: begin
        cmd.drop_chk = 1'b1;
        state_nxt    = ST_R_DREQ;
      end
      ST_R_DFIN: begin
        cmd.drop_fin = 1'b1;
        cmd.held_rd  = 1'b1;
        state_nxt    = ST_R_HGET;
      end
      ST_R_HGET: begin
        cmd.h_load  = 1'b1;
        cmd.held_wr = 1'b1;
        cmd.held_fn = HELD_ZERO;
        state_nxt   = ST_R_HLOOP;
      end
      ST_R_HLOOP: begin
        if (stat.h_zero) begin
          state_nxt = ST_R_NEXT;
        end else begin
          cmd.h_dec = 1'b1;
          state_nxt = ST_GB_UP;
        end
      end
      ST_R_NEXT: begin
        if (stat.res_last) begin
          state_nxt = ST_R_DONE;
        end else begin
          cmd.res_inc = 1'b1;
          state_nxt   = ST_R_SETUP;
        end
      end
      ST_R_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_RELEASED;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/counting_semaphore_table_core.sv @@
`timescale 1ns / 1ps
// After reset the block sweeps each entry of its held count memory to zero
// (NUM_RESOURCES rounded up to a power of two times NUM_PIDS rounded up to a
// power of two entries, 256 at the defaults); no item is accepted until then.
// Items are handled one at a time by a state machine over the shared memory
// ports: a wait reads the held count, then executes; a signal lowers it, gives
// a unit back and on a wakeup pops the queue, raises the woken process's held
// count and scans the rest of the queue for it. A release visits every
// resource in turn, dropping the process's queued waits, then running one
// give-back per unit it held there. Each result leaves through a register;
// while the next stage holds it off, the next result waits until it drains.
// ----------------------------------------------------------------------------
// Counting semaphore table core
// Table of counting semaphores with FIFO wait queues and per-process holdings.
// ----------------------------------------------------------------------------
module counting_semaphore_table_core import cst_pkg::*; #(
  parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
  parameter int NUM_PIDS      = NUM_PIDS_DEF,
  parameter int WAIT_DEPTH    = WAIT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cst_in_if.sink     in_ch,
  cst_out_if.source  out_ch
);

  cst_cmd_t  cmd;
  cst_stat_t stat;
  logic      ctrl_ready;

  assign in_ch.ready = ctrl_ready;

  cst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (ctrl_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cst_dp #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .NUM_PIDS      (NUM_PIDS),
    .WAIT_DEPTH    (WAIT_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_action   (in_ch.action),
    .in_resource (in_ch.resource),
    .in_pid      (in_ch.pid),
    .cmd         (cmd),
    .stat        (stat),
    .out_ch      (out_ch)
  );

endmodule

@@ sim/counting_semaphore_table_core_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore table checker
// Watches the request and result channels, predicts every result from a
// private copy of the semaphore table and compares each field in order.
// ----------------------------------------------------------------------------
module counting_semaphore_table_core_checker import cst_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  cst_in_if      in_ch,
  cst_out_if     out_ch,
  output int     fail_count,
  output int     pending_results
);

  localparam int NRES  = NUM_RESOURCES_DEF;
  localparam int NPID  = NUM_PIDS_DEF;
  localparam int DEPTH = WAIT_DEPTH_DEF;

  typedef struct packed {
    kind_t            kind;
    logic [PID_W-1:0] who;
    logic [RES_W-1:0] which_resource;
    logic             last;
  } sem_result_t;

  int               count_tab [NRES];
  int               held_tab  [NRES][NPID];
  int               fifo_tab  [NRES][$];
  sem_result_t      expected_results [$];

  function automatic void push_result(kind_t k, int who, int r);
    sem_result_t e;
    e.kind = k;
    e.who = PID_W'(who);
    e.which_resource = RES_W'(r);
    e.last = 1'b0;
    expected_results.push_back(e);
  endfunction

  function automatic void return_unit(int r);
    int q;
    if (count_tab[r] < 127) count_tab[r]++;
    if (count_tab[r] > 0 || fifo_tab[r].size() == 0) return;
    q = fifo_tab[r].pop_front();
    if (held_tab[r][q] < 255) held_tab[r][q]++;
    foreach (fifo_tab[r][i]) if (fifo_tab[r][i] == q) return;
    push_result(KIND_WOKEN, q, r);
  endfunction

  function automatic void predict_request(action_t a, int r, int p);
    int before_n;
    int h;
    int kept [$];
    before_n = expected_results.size();
    case (a)
      ACT_WAIT: begin
        if (count_tab[r] - 1 >= 0) begin
          count_tab[r]--;
          if (held_tab[r][p] < 255) held_tab[r][p]++;
          push_result(KIND_GRANTED, p, r);
        end else if (fifo_tab[r].size() >= DEPTH) begin
          push_result(KIND_REFUSED, p, r);
        end else begin
          if (count_tab[r] > -128) count_tab[r]--;
          fifo_tab[r].push_back(p);
          push_result(KIND_BLOCKED, p, r);
        end
      end
      ACT_SIGNAL: begin
        if (held_tab[r][p] > 0) held_tab[r][p]--;
        return_unit(r);
        push_result(KIND_SIGNALED, p, r);
      end
      ACT_RELEASE: begin
        for (int k = 0; k < NRES; k++) begin
          kept.delete();
          foreach (fifo_tab[k][i]) begin
            if (fifo_tab[k][i] == p) begin
              if (count_tab[k] < 127) count_tab[k]++;
            end else begin
              kept.push_back(fifo_tab[k][i]);
            end
          end
          fifo_tab[k] = kept;
          h = held_tab[k][p];
          held_tab[k][p] = 0;
          repeat (h) return_unit(k);
        end
        push_result(KIND_RELEASED, p, 0);
      end
      default: ;
    endcase
    if (expected_results.size() > before_n)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  initial begin
    for (int r = 0; r < NRES; r++) begin
      count_tab[r] = 1;
      for (int p = 0; p < NPID; p++) held_tab[r][p] = 0;
    end
    fail_count = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin
    sem_result_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result kind %0d who %0d", out_ch.kind, out_ch.who);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_ch.kind != e.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, out_ch.kind);
            fail_count++;
          end
          if (out_ch.who != e.who) begin
            $error("who: expected %0d actual %0d", e.who, out_ch.who);
            fail_count++;
          end
          if (out_ch.which_resource != e.which_resource) begin
            $error("which_resource: expected %0d actual %0d", e.which_resource,
                   out_ch.which_resource);
            fail_count++;
          end
          if (out_ch.last != e.last) begin
            $error("last: expected %0d actual %0d", e.last, out_ch.last);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_request(action_t'(in_ch.action), int'(in_ch.resource) % NRES,
                        int'(in_ch.pid) % NPID);
    end
    pending_results = expected_results.size();
  end

endmodule

@@ sim/counting_semaphore_table_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore table testbench
// Drives directed and random wait, signal and release requests under several
// idling patterns and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module counting_semaphore_table_core_tb;
  import cst_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_results;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;

  cst_in_if  in_ch ();
  cst_out_if out_ch ();

  counting_semaphore_table_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  counting_semaphore_table_core_checker checker_inst (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.resource = '0;
    in_ch.pid = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
    if (cycle_count > 400000) begin
      $display("counting_semaphore_table_core: mismatch");
      $finish;
    end
  end

  task automatic send_request(action_t a, int r, int p);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) in_ch.valid <= 1'b0;
    repeat (gap) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.action <= a;
    in_ch.resource <= RES_W'(r);
    in_ch.pid <= PID_W'(p);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic random_request(int pid_span);
    int pick;
    action_t a;
    pick = $urandom_range(99);
    if (pick < 50) a = ACT_WAIT;
    else if (pick < 85) a = ACT_SIGNAL;
    else if (pick < 96) a = ACT_RELEASE;
    else a = ACT_IGNORE;
    send_request(a, (pick % 3 == 0) ? $urandom_range(7) : $urandom_range(1),
                 (pid_span == 31) ? $urandom_range(31) : $urandom_range(pid_span));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_request(ACT_WAIT, 0, 0);
    send_request(ACT_WAIT, 0, 1);
    send_request(ACT_WAIT, 0, 2);
    send_request(ACT_WAIT, 0, 1);
    send_request(ACT_WAIT, 0, 3);
    send_request(ACT_WAIT, 0, 4);
    send_request(ACT_SIGNAL, 0, 0);
    send_request(ACT_SIGNAL, 0, 31);
    send_request(ACT_RELEASE, 0, 1);
    send_request(ACT_IGNORE, 7, 31);
    send_request(ACT_WAIT, 7, 31);
    send_request(ACT_WAIT, 7, 31);
    send_request(ACT_RELEASE, 5, 31);
    send_request(ACT_SIGNAL, 3, 5);
    send_request(ACT_RELEASE, 2, 0);
    for (int i = 0; i < 6; i++) send_request(ACT_SIGNAL, 6, 9);
    send_request(ACT_WAIT, 6, 10);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 63 : 17) : 0;
      stall_pct = (ph == 2) ? 63 : ((ph == 3) ? 17 : 0);
      for (int i = 0; i < 50; i++) random_request((i % 4 == 0) ? 31 : 5);
    end
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("counting_semaphore_table_core: match");
    end else begin
      $display("counting_semaphore_table_core: mismatch");
    end
    $finish;
  end

endmodule
